/* rtl/core/cutoff_tracked_resonance_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cutoff tracked resonance block
// Each macro expands to a labeled concurrent assertion on clk and rst_n, or to
// nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef CUTOFF_TRACKED_RESONANCE_MACROS_SVH
`define CUTOFF_TRACKED_RESONANCE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define CTR_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define CTR_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`else

`define CTR_ASSERT_HOLDS(label, cond, msg)
`define CTR_ASSERT_IMP(label, pre, post, msg)

`endif

`endif

/* rtl/core/ctr_pkg.sv */
// ----------------------------------------------------------------------------
// Cutoff tracked resonance package
// Configuration types, register and curve codes, and the elaboration-time
// functions that fill the exponential and logarithmic curve tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ctr_pkg;

    localparam int CUT_W      = 16;
    localparam int RES_W      = 16;
    localparam int RECIP_W    = 32;
    localparam int AMT_W      = 17;
    localparam int CURVE_W    = 3;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [AMT_W-1:0] AMT_FULL = AMT_W'(65536);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RIDE_ENABLED      = 3'd0,
        REG_CURVE_SELECT      = 3'd1,
        REG_CUTOFF_FLOOR      = 3'd2,
        REG_CUTOFF_CEILING    = 3'd3,
        REG_SPAN_RECIPROCAL   = 3'd4,
        REG_RESONANCE_FLOOR   = 3'd5,
        REG_RESONANCE_CEILING = 3'd6,
        REG_RIDE_AMOUNT       = 3'd7
    } reg_index_t;

    typedef enum logic [CURVE_W-1:0] {
        CURVE_EXP    = 3'd0,
        CURVE_LOG    = 3'd1,
        CURVE_SMOOTH = 3'd2,
        CURVE_LINEAR = 3'd3,
        CURVE_BLEND  = 3'd4
    } curve_t;

    typedef struct packed {
        logic                 ride_enabled;
        logic [CURVE_W-1:0]   curve_select;
        logic [CUT_W-1:0]     cutoff_floor;
        logic [CUT_W-1:0]     cutoff_ceiling;
        logic [RECIP_W-1:0]   span_reciprocal;
        logic [RES_W-1:0]     resonance_floor;
        logic [RES_W-1:0]     resonance_ceiling;
        logic [AMT_W-1:0]     ride_amount;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ride_enabled:      1'b0,
        curve_select:      CURVE_EXP,
        cutoff_floor:      16'd20,
        cutoff_ceiling:    16'd20000,
        span_reciprocal:   32'd215,
        resonance_floor:   16'd0,
        resonance_ceiling: 16'd62259,
        ride_amount:       17'd32768
    };

    // Restoring division; only ever evaluated while the tables are built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-x) by its series, x in Q24, result in Q32.
    function automatic logic [63:0] neg_exp_q32(input logic [63:0] x24);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        int          k;
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        for (k = 1; k < 48 && term != 64'd0; k++)
        begin
            term = udiv64((term * x24) >> 24, 64'(k));
            if (k % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    // log2 of a Q30 value of at least one, result in Q30.
    function automatic logic [63:0] log2_q30(input logic [63:0] y_in);
        logic [63:0] y;
        logic [63:0] r;
        int          n;
        int          b;
        y = y_in;
        r = '0;
        for (n = 0; n < 8; n++)
        begin
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                r = r + (64'd1 << 30);
            end
        end
        for (b = 29; b >= 0; b--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30))
            begin
                y    = y >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    // Exponential table entry: 1 - e^(-3 i / size) with fb fraction bits.
    function automatic logic [63:0] exp_entry(input logic [63:0] i, input logic [63:0] size,
                                              input int fb);
        logic [63:0] one_q;
        logic [63:0] x24;
        logic [63:0] e;
        logic [63:0] eq;
        one_q = 64'd1 << fb;
        x24   = udiv64((64'd3 * i) << 24, size);
        e     = neg_exp_q32(x24);
        eq    = (e + (64'd1 << (31 - fb))) >> (32 - fb);
        if (eq > one_q)
            eq = one_q;
        return one_q - eq;
    endfunction

    // Logarithmic table entry: log10(1 + 9 i / size) with fb fraction bits.
    function automatic logic [63:0] log_entry(input logic [63:0] i, input logic [63:0] size,
                                              input int fb);
        logic [63:0] l10;
        logic [63:0] y;
        logic [63:0] ly;
        l10 = log2_q30(64'd10 << 30);
        y   = (64'd1 << 30) + udiv64((64'd9 * i) << 30, size);
        ly  = log2_q30(y);
        return udiv64((ly << fb) + (l10 >> 1), l10);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ctr_position.sv */
// ----------------------------------------------------------------------------
// Cutoff position stages
// Clamps the cutoff to the tracked range, scales it by the span reciprocal and
// hands on the inverted position 1 - p with the base resonance, in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_position #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctr_pkg::cfg_t                 cfg,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [ctr_pkg::CUT_W-1:0]     up_cutoff,
    input  logic [ctr_pkg::RES_W-1:0]     up_resonance,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic [FRACTION_BITS:0]        dn_inv_position,
    output logic [ctr_pkg::RES_W-1:0]     dn_resonance
);

    localparam int FB     = FRACTION_BITS;
    localparam int PW     = FB + 1;
    localparam int PROD_W = ctr_pkg::CUT_W + ctr_pkg::RECIP_W;
    localparam int SH     = ctr_pkg::RECIP_W - FB;
    localparam int PRAW_W = PROD_W - SH;
    localparam logic [PW-1:0] ONE = PW'(1) << FB;

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic s1_en, s2_en, s3_en;

    logic [ctr_pkg::CUT_W-1:0]  clamp_hi;
    logic [ctr_pkg::CUT_W-1:0]  clamp_lo;
    logic [ctr_pkg::CUT_W-1:0]  diff_next, diff_reg;
    logic [ctr_pkg::RES_W-1:0]  s1_res_reg, s2_res_reg, s3_res_reg;
    logic [PROD_W-1:0]          prod_next, prod_reg;
    logic [PRAW_W-1:0]          p_raw;
    logic [PW-1:0]              p_sat;
    logic [PW-1:0]              v_next, v_reg;

    assign s3_en    = !s3_vld_reg || dn_ready;
    assign s2_en    = !s2_vld_reg || s3_en;
    assign s1_en    = !s1_vld_reg || s2_en;
    assign up_ready = s1_en;

    always_comb
    begin
        clamp_hi  = (up_cutoff > cfg.cutoff_ceiling) ? cfg.cutoff_ceiling : up_cutoff;
        clamp_lo  = (clamp_hi < cfg.cutoff_floor) ? cfg.cutoff_floor : clamp_hi;
        diff_next = clamp_lo - cfg.cutoff_floor;

        prod_next = PROD_W'(diff_reg) * PROD_W'(cfg.span_reciprocal);

        // A collapsed range leaves the position at zero; a large product saturates.
        p_raw = prod_reg[PROD_W-1:SH];
        if (cfg.cutoff_ceiling == cfg.cutoff_floor)
            p_sat = '0;
        else if (p_raw > PRAW_W'(ONE))
            p_sat = ONE;
        else
            p_sat = p_raw[PW-1:0];
        v_next = ONE - p_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_vld_reg <= up_valid;
            if (s2_en)
                s2_vld_reg <= s1_vld_reg;
            if (s3_en)
                s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            diff_reg   <= diff_next;
            s1_res_reg <= up_resonance;
        end
        if (s2_en)
        begin
            prod_reg   <= prod_next;
            s2_res_reg <= s1_res_reg;
        end
        if (s3_en)
        begin
            v_reg      <= v_next;
            s3_res_reg <= s2_res_reg;
        end
    end

    assign dn_valid        = s3_vld_reg;
    assign dn_inv_position = v_reg;
    assign dn_resonance    = s3_res_reg;

endmodule

`default_nettype wire

/* rtl/core/ctr_curve.sv */
// ----------------------------------------------------------------------------
// Curve shaping stages
// Maps the inverted position through the selected curve: table reads (with
// interpolation for exp), smoothstep, linear, or the exp and smoothstep blend.
// Six stages; the blend divides by ten through a reciprocal and one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_curve #(
    parameter int FRACTION_BITS    = 16,
    parameter int CURVE_TABLE_SIZE = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctr_pkg::cfg_t                 cfg,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [FRACTION_BITS:0]        up_inv_position,
    input  logic [ctr_pkg::RES_W-1:0]     up_resonance,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic [FRACTION_BITS:0]        dn_curve,
    output logic [ctr_pkg::RES_W-1:0]     dn_resonance
);

    localparam int FB    = FRACTION_BITS;
    localparam int PW    = FB + 1;
    localparam int S     = CURVE_TABLE_SIZE;
    localparam int IW    = $clog2(S + 1);
    localparam int POS_W = PW + IW;
    localparam int VV_W  = 2 * PW;
    localparam int TW_W  = PW + 1;
    localparam int SMP_W = PW + TW_W;
    localparam int IP_W  = PW + FB;
    localparam int MIX_W = FB + 4;
    localparam int MUL_W = 2 * MIX_W;

    localparam logic [TW_W-1:0]  THREE_ONE = TW_W'(3) << FB;
    localparam logic [MIX_W-1:0] SEVEN     = MIX_W'(7);
    localparam logic [MIX_W-1:0] THREE     = MIX_W'(3);
    localparam logic [MIX_W-1:0] TEN       = MIX_W'(10);
    localparam logic [MIX_W-1:0] RECIP10   = MIX_W'((64'd1 << MIX_W) / 10);

    // Exponential table words hold the step to the next entry above the value.
    logic [2*PW-1:0] exp_rom [0:S];
    logic [PW-1:0]   log_rom [0:S];

    for (genvar gi = 0; gi <= S; gi++)
    begin : g_rom
        localparam logic [63:0] E_LO = ctr_pkg::exp_entry(64'(gi), 64'(S), FB);
        localparam logic [63:0] E_HI = (gi < S) ?
                                       ctr_pkg::exp_entry(64'(gi + 1), 64'(S), FB) : E_LO;
        localparam logic [63:0] L_V  = ctr_pkg::log_entry(64'(gi), 64'(S), FB);
        assign exp_rom[gi] = {PW'(E_HI - E_LO), PW'(E_LO)};
        assign log_rom[gi] = PW'(L_V);
    end

    logic c1_vld_reg, c2_vld_reg, c3_vld_reg, c4_vld_reg, c5_vld_reg, c6_vld_reg;
    logic c1_en, c2_en, c3_en, c4_en, c5_en, c6_en;

    logic [ctr_pkg::RES_W-1:0] c1_res_reg, c2_res_reg, c3_res_reg;
    logic [ctr_pkg::RES_W-1:0] c4_res_reg, c5_res_reg, c6_res_reg;

    logic [POS_W-1:0]  pos_next, pos_reg;
    logic [VV_W-1:0]   vv_next, vv_reg;
    logic [PW-1:0]     c1_v_reg, c2_v_reg, c3_v_reg;

    logic [IW-1:0]     rom_idx;
    logic [PW-1:0]     sq;
    logic [TW_W-1:0]   tw;
    logic [SMP_W-1:0]  smp_next, smp_reg;
    logic [FB-1:0]     frac_next, frac_reg;
    logic [2*PW-1:0]   exp_word_reg;
    logic [PW-1:0]     log_val_reg;

    logic [IP_W-1:0]   ip_next, ip_reg;
    logic [PW-1:0]     smooth_next, smooth_reg;
    logic [PW-1:0]     c3_exp_base_reg, c3_log_reg;

    logic [PW-1:0]     exp_val;
    logic [PW-1:0]     pick_next, c4_pick_reg, c5_pick_reg;
    logic [MIX_W-1:0]  mix_next, c4_mix_reg, c5_mix_reg;

    logic [MUL_W-1:0]  mul_next, mul_reg;

    logic [MIX_W-1:0]  quo_est;
    logic [MIX_W-1:0]  rem_est;
    logic [MIX_W-1:0]  quo;
    logic [PW-1:0]     curve_next, curve_reg;

    assign c6_en    = !c6_vld_reg || dn_ready;
    assign c5_en    = !c5_vld_reg || c6_en;
    assign c4_en    = !c4_vld_reg || c5_en;
    assign c3_en    = !c3_vld_reg || c4_en;
    assign c2_en    = !c2_vld_reg || c3_en;
    assign c1_en    = !c1_vld_reg || c2_en;
    assign up_ready = c1_en;

    always_comb
    begin
        pos_next = POS_W'(up_inv_position) * POS_W'(S);
        vv_next  = VV_W'(up_inv_position) * VV_W'(up_inv_position);

        rom_idx   = pos_reg[FB+IW-1:FB];
        frac_next = pos_reg[FB-1:0];
        sq        = vv_reg[FB+PW-1:FB];
        tw        = THREE_ONE - ({1'b0, c1_v_reg} << 1);
        smp_next  = SMP_W'(sq) * SMP_W'(tw);

        ip_next     = IP_W'(exp_word_reg[2*PW-1:PW]) * IP_W'(frac_reg);
        smooth_next = smp_reg[FB+PW-1:FB];

        exp_val = c3_exp_base_reg + ip_reg[FB+PW-1:FB];
        case (cfg.curve_select)
            ctr_pkg::CURVE_EXP:    pick_next = exp_val;
            ctr_pkg::CURVE_LOG:    pick_next = c3_log_reg;
            ctr_pkg::CURVE_SMOOTH: pick_next = smooth_reg;
            ctr_pkg::CURVE_LINEAR: pick_next = c3_v_reg;
            default:               pick_next = '0;
        endcase
        mix_next = MIX_W'(exp_val) * SEVEN + MIX_W'(smooth_reg) * THREE;

        mul_next = MUL_W'(c4_mix_reg) * MUL_W'(RECIP10);

        // The truncated reciprocal can come out one low; one compare fixes it.
        quo_est = mul_reg[MUL_W-1:MIX_W];
        rem_est = c5_mix_reg - quo_est * TEN;
        quo     = (rem_est >= TEN) ? quo_est + MIX_W'(1) : quo_est;
        if (cfg.curve_select == ctr_pkg::CURVE_BLEND)
            curve_next = quo[PW-1:0];
        else
            curve_next = c5_pick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            c3_vld_reg <= 1'b0;
            c4_vld_reg <= 1'b0;
            c5_vld_reg <= 1'b0;
            c6_vld_reg <= 1'b0;
        end
        else
        begin
            if (c1_en)
                c1_vld_reg <= up_valid;
            if (c2_en)
                c2_vld_reg <= c1_vld_reg;
            if (c3_en)
                c3_vld_reg <= c2_vld_reg;
            if (c4_en)
                c4_vld_reg <= c3_vld_reg;
            if (c5_en)
                c5_vld_reg <= c4_vld_reg;
            if (c6_en)
                c6_vld_reg <= c5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c1_en)
        begin
            pos_reg    <= pos_next;
            vv_reg     <= vv_next;
            c1_v_reg   <= up_inv_position;
            c1_res_reg <= up_resonance;
        end
        if (c2_en)
        begin
            exp_word_reg <= exp_rom[rom_idx];
            log_val_reg  <= log_rom[rom_idx];
            frac_reg     <= frac_next;
            smp_reg      <= smp_next;
            c2_v_reg     <= c1_v_reg;
            c2_res_reg   <= c1_res_reg;
        end
        if (c3_en)
        begin
            ip_reg          <= ip_next;
            smooth_reg      <= smooth_next;
            c3_exp_base_reg <= exp_word_reg[PW-1:0];
            c3_log_reg      <= log_val_reg;
            c3_v_reg        <= c2_v_reg;
            c3_res_reg      <= c2_res_reg;
        end
        if (c4_en)
        begin
            c4_pick_reg <= pick_next;
            c4_mix_reg  <= mix_next;
            c4_res_reg  <= c3_res_reg;
        end
        if (c5_en)
        begin
            mul_reg     <= mul_next;
            c5_pick_reg <= c4_pick_reg;
            c5_mix_reg  <= c4_mix_reg;
            c5_res_reg  <= c4_res_reg;
        end
        if (c6_en)
        begin
            curve_reg  <= curve_next;
            c6_res_reg <= c5_res_reg;
        end
    end

    assign dn_valid     = c6_vld_reg;
    assign dn_curve     = curve_reg;
    assign dn_resonance = c6_res_reg;

endmodule

`default_nettype wire

/* rtl/core/ctr_ride.sv */
// ----------------------------------------------------------------------------
// Ride scaling stages
// Scales the curve value by the ride amount and the resonance span, adds it
// to the base resonance and clamps, or passes the base through when disabled.
// Three stages; the last one is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_ride #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctr_pkg::cfg_t                 cfg,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [FRACTION_BITS:0]        up_curve,
    input  logic [ctr_pkg::RES_W-1:0]     up_resonance,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic [ctr_pkg::RES_W-1:0]     dn_resonance
);

    localparam int FB    = FRACTION_BITS;
    localparam int PW    = FB + 1;
    localparam int AW    = ctr_pkg::AMT_W;
    localparam int RW    = ctr_pkg::RES_W;
    localparam int PA_W  = PW + AW;
    localparam int PB_W  = PW + RW;
    localparam int MAG_W = RW + 1;
    localparam int SUM_W = RW + 3;

    logic r1_vld_reg, r2_vld_reg, r3_vld_reg;
    logic r1_en, r2_en, r3_en;

    logic [AW-1:0]    amt;
    logic [PA_W-1:0]  pa_next, pa_reg;
    logic [PW-1:0]    ride_a;
    logic             span_neg;
    logic [RW-1:0]    span_mag;
    logic [PB_W-1:0]  pb_next, pb_reg;
    logic [RW-1:0]    r1_res_reg, r2_res_reg;

    logic [MAG_W-1:0]        add_mag;
    logic signed [SUM_W-1:0] base_s;
    logic signed [SUM_W-1:0] add_s;
    logic signed [SUM_W-1:0] sum_s;
    logic signed [SUM_W-1:0] ceil_s;
    logic signed [SUM_W-1:0] floor_s;
    logic signed [SUM_W-1:0] clip_hi;
    logic signed [SUM_W-1:0] clip_lo;
    logic [RW-1:0]           result_next, result_reg;

    assign r3_en    = !r3_vld_reg || dn_ready;
    assign r2_en    = !r2_vld_reg || r3_en;
    assign r1_en    = !r1_vld_reg || r2_en;
    assign up_ready = r1_en;

    always_comb
    begin
        amt     = (cfg.ride_amount > ctr_pkg::AMT_FULL) ? ctr_pkg::AMT_FULL : cfg.ride_amount;
        pa_next = PA_W'(up_curve) * PA_W'(amt);

        // The ride amount is at most one, so the scaled curve stays within PW bits.
        ride_a   = pa_reg[16+PW-1:16];
        span_neg = cfg.resonance_ceiling < cfg.resonance_floor;
        span_mag = span_neg ? cfg.resonance_floor - cfg.resonance_ceiling
                            : cfg.resonance_ceiling - cfg.resonance_floor;
        pb_next  = PB_W'(ride_a) * PB_W'(span_mag);

        add_mag = pb_reg[FB+MAG_W-1:FB];
        base_s  = $signed({3'b000, r2_res_reg});
        add_s   = $signed({2'b00, add_mag});
        sum_s   = span_neg ? base_s - add_s : base_s + add_s;
        ceil_s  = $signed({3'b000, cfg.resonance_ceiling});
        floor_s = $signed({3'b000, cfg.resonance_floor});
        // The floor is applied last, so it wins when the range is inverted.
        clip_hi = (sum_s > ceil_s) ? ceil_s : sum_s;
        clip_lo = (clip_hi < floor_s) ? floor_s : clip_hi;
        result_next = cfg.ride_enabled ? clip_lo[RW-1:0] : r2_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
            r3_vld_reg <= 1'b0;
        end
        else
        begin
            if (r1_en)
                r1_vld_reg <= up_valid;
            if (r2_en)
                r2_vld_reg <= r1_vld_reg;
            if (r3_en)
                r3_vld_reg <= r2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1_en)
        begin
            pa_reg     <= pa_next;
            r1_res_reg <= up_resonance;
        end
        if (r2_en)
        begin
            pb_reg     <= pb_next;
            r2_res_reg <= r1_res_reg;
        end
        if (r3_en)
            result_reg <= result_next;
    end

    assign dn_valid     = r3_vld_reg;
    assign dn_resonance = result_reg;

endmodule

`default_nettype wire

/* rtl/core/cutoff_tracked_resonance.sv */
// ----------------------------------------------------------------------------
// Cutoff tracked resonance
// Raises the resonance as the filter cutoff falls within a configured range,
// following one of five curves, and clamps it to the resonance range.
//
//   Channel   Handshake                     Payload
//   item      item_valid / item_ready       base_cutoff, base_resonance
//   result    result_valid / result_ready   effective_resonance
//   config    cfg_we                        cfg_index, cfg_data
//
// One word is accepted per clock when the result side keeps up.
// Words pass through three position stages, six curve stages and three ride
// stages on their way from the input to the result.
// Reset clears all valid bits and loads the register reset values; the curve
// tables are constant and need no fill.
// A low result_ready holds words in place; item_ready stays high while any stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cutoff_tracked_resonance_macros.svh"

module cutoff_tracked_resonance #(
    parameter int CURVE_TABLE_SIZE = 256,
    parameter int FRACTION_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ctr_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [ctr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [ctr_pkg::CUT_W-1:0]         base_cutoff,
    input  logic [ctr_pkg::RES_W-1:0]         base_resonance,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [ctr_pkg::RES_W-1:0]         effective_resonance
);

    localparam int PW = FRACTION_BITS + 1;
    localparam logic [PW-1:0] ONE = PW'(1) << FRACTION_BITS;

    ctr_pkg::cfg_t cfg_reg, cfg_next;

    logic                      pos_valid, pos_ready;
    logic [PW-1:0]             pos_v;
    logic [ctr_pkg::RES_W-1:0] pos_res;
    logic                      curve_valid, curve_ready;
    logic [PW-1:0]             curve_val;
    logic [ctr_pkg::RES_W-1:0] curve_res;

    always_comb
    begin
        cfg_next = cfg_reg;
        case (cfg_index)
            ctr_pkg::REG_RIDE_ENABLED:      cfg_next.ride_enabled      = cfg_data[0];
            ctr_pkg::REG_CURVE_SELECT:      cfg_next.curve_select      = cfg_data[2:0];
            ctr_pkg::REG_CUTOFF_FLOOR:      cfg_next.cutoff_floor      = cfg_data[15:0];
            ctr_pkg::REG_CUTOFF_CEILING:    cfg_next.cutoff_ceiling    = cfg_data[15:0];
            ctr_pkg::REG_SPAN_RECIPROCAL:   cfg_next.span_reciprocal   = cfg_data[31:0];
            ctr_pkg::REG_RESONANCE_FLOOR:   cfg_next.resonance_floor   = cfg_data[15:0];
            ctr_pkg::REG_RESONANCE_CEILING: cfg_next.resonance_ceiling = cfg_data[15:0];
            ctr_pkg::REG_RIDE_AMOUNT:       cfg_next.ride_amount       = cfg_data[16:0];
            default:                        cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= ctr_pkg::CFG_RESET;
        else if (cfg_we)
            cfg_reg <= cfg_next;
    end

    ctr_position #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_position (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .up_valid       (item_valid),
        .up_ready       (item_ready),
        .up_cutoff      (base_cutoff),
        .up_resonance   (base_resonance),
        .dn_valid       (pos_valid),
        .dn_ready       (pos_ready),
        .dn_inv_position(pos_v),
        .dn_resonance   (pos_res)
    );

    ctr_curve #(
        .FRACTION_BITS   (FRACTION_BITS),
        .CURVE_TABLE_SIZE(CURVE_TABLE_SIZE)
    ) u_curve (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .up_valid       (pos_valid),
        .up_ready       (pos_ready),
        .up_inv_position(pos_v),
        .up_resonance   (pos_res),
        .dn_valid       (curve_valid),
        .dn_ready       (curve_ready),
        .dn_curve       (curve_val),
        .dn_resonance   (curve_res)
    );

    ctr_ride #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ride (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .up_valid    (curve_valid),
        .up_ready    (curve_ready),
        .up_curve    (curve_val),
        .up_resonance(curve_res),
        .dn_valid    (result_valid),
        .dn_ready    (result_ready),
        .dn_resonance(effective_resonance)
    );

    // An empty output register lets the whole chain move, so input must be open.
    `CTR_ASSERT_HOLDS(a_ready_when_drained, result_valid || item_ready, "item_ready low")
    `CTR_ASSERT_IMP(a_position_in_range, pos_valid, pos_v <= ONE, "inverted position above one")
    `CTR_ASSERT_IMP(a_curve_in_range, curve_valid, curve_val <= ONE, "curve value above one")

endmodule

`default_nettype wire

/* tb/tb_cutoff_tracked_resonance.sv */
// ----------------------------------------------------------------------------
// Testbench for the cutoff tracked resonance block
// A table of directed words comes first, then random words under a series of
// register settings, with random gaps on both channels and one long stall at
// the result side. Each result is checked in order against a known value
// or a local model of the block with its own copies of the two curve tables.
// ----------------------------------------------------------------------------
module tb_cutoff_tracked_resonance;

    import ctr_pkg::*;

    localparam int TABLE_SIZE        = 256;
    localparam int FRAC_BITS         = 16;
    localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;
    localparam int DRAIN_CYCLES      = 16;
    localparam int LONG_STALL        = 300;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int SETTINGS_PER_PASS = 5;
    localparam int WORDS_PER_SETTING = 80;

    // Curve codes that the block does not define.
    localparam logic [CURVE_W-1:0] CURVE_UNUSED_LO = 3'd5;
    localparam logic [CURVE_W-1:0] CURVE_UNUSED_HI = 3'd7;

    typedef struct {
        cfg_t         cfg;
        logic [15:0]  cutoff;
        logic [15:0]  resonance;
        bit           known;
        logic [15:0]  known_value;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    reg_index_t            cfg_index = REG_RIDE_ENABLED;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    logic [CUT_W-1:0]      base_cutoff = '0;
    logic [RES_W-1:0]      base_resonance = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [RES_W-1:0]      effective_resonance;

    logic [31:0]  exp_curve [0:TABLE_SIZE];
    logic [31:0]  log_curve [0:TABLE_SIZE];
    cfg_t         active_cfg = CFG_RESET;
    logic [15:0]  resonance_due [$];
    stim_row_t    stim_table [$];
    int           failures = 0;
    int           send_idle_pct = 33;
    int           recv_idle_pct = 67;
    bit           stall_due = 1'b0;

    cutoff_tracked_resonance #(
        .CURVE_TABLE_SIZE(TABLE_SIZE),
        .FRACTION_BITS(FRAC_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .base_cutoff(base_cutoff),
        .base_resonance(base_resonance),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .effective_resonance(effective_resonance)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // e^(-x) by its power series, x in Q24 and the result in Q32.
    function automatic logic [63:0] decay_q32(input logic [63:0] x24);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        for (int k = 1; k < 48 && term != 64'd0; k++)
        begin
            term = ((term * x24) >> 24) / 64'(k);
            if (k % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    // Binary logarithm in Q30 by repeated squaring.
    function automatic logic [63:0] log2_fixed30(input logic [63:0] y_in);
        logic [63:0] y;
        logic [63:0] r;
        y = y_in;
        r = '0;
        while (y >= (64'd2 << 30))
        begin
            y = y >> 1;
            r = r + (64'd1 << 30);
        end
        for (int b = 29; b >= 0; b--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30))
            begin
                y    = y >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void fill_curve_tables();
        logic [63:0] l10;
        logic [63:0] x24;
        logic [63:0] e;
        logic [63:0] eq;
        logic [63:0] y;
        logic [63:0] ly;
        l10 = log2_fixed30(64'd10 << 30);
        for (int i = 0; i <= TABLE_SIZE; i++)
        begin
            x24 = ((64'd3 * 64'(i)) << 24) / 64'(TABLE_SIZE);
            e   = decay_q32(x24);
            eq  = (e + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
            if (eq > ONE)
                eq = ONE;
            exp_curve[i] = 32'(ONE - eq);
            y  = (64'd1 << 30) + (((64'd9 * 64'(i)) << 30) / 64'(TABLE_SIZE));
            ly = log2_fixed30(y);
            log_curve[i] = 32'(((ly << FRAC_BITS) + (l10 >> 1)) / l10);
        end
    endfunction

    function automatic logic [63:0] exp_shape(input logic [63:0] v);
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] frac;
        logic [31:0] rise;
        pos  = v * 64'(TABLE_SIZE);
        idx  = pos >> FRAC_BITS;
        frac = pos & (ONE - 1);
        if (idx >= 64'(TABLE_SIZE))
            return 64'(exp_curve[TABLE_SIZE]);
        rise = exp_curve[idx + 1] - exp_curve[idx];
        return 64'(exp_curve[idx]) + ((64'(rise) * frac) >> FRAC_BITS);
    endfunction

    function automatic logic [63:0] smooth_shape(input logic [63:0] v);
        logic [63:0] sq;
        sq = (v * v) >> FRAC_BITS;
        return (sq * (64'd3 * ONE - 64'd2 * v)) >> FRAC_BITS;
    endfunction

    function automatic logic [15:0] predict_resonance(input cfg_t c, input logic [15:0] cut_in,
                                                      input logic [15:0] base_in);
        logic [63:0] cut;
        logic [63:0] pos;
        logic [63:0] v;
        logic [63:0] shaped;
        logic [63:0] idx;
        logic [63:0] amt;
        longint      ride;
        longint      span;
        longint      add;
        longint      res;
        longint      res_lo;
        longint      res_hi;
        if (!c.ride_enabled)
            return base_in;
        cut = 64'(cut_in);
        if (cut > 64'(c.cutoff_ceiling))
            cut = 64'(c.cutoff_ceiling);
        if (cut < 64'(c.cutoff_floor))
            cut = 64'(c.cutoff_floor);
        pos = '0;
        if (c.cutoff_ceiling != c.cutoff_floor)
        begin
            pos = ((cut - 64'(c.cutoff_floor)) * 64'(c.span_reciprocal)) >> (32 - FRAC_BITS);
            if (pos > ONE)
                pos = ONE;
        end
        v = ONE - pos;
        case (c.curve_select)
            CURVE_EXP:    shaped = exp_shape(v);
            CURVE_LOG:
            begin
                idx = (v * 64'(TABLE_SIZE)) >> FRAC_BITS;
                if (idx > 64'(TABLE_SIZE))
                    idx = 64'(TABLE_SIZE);
                shaped = 64'(log_curve[idx]);
            end
            CURVE_SMOOTH: shaped = smooth_shape(v);
            CURVE_LINEAR: shaped = v;
            CURVE_BLEND:  shaped = (64'd7 * exp_shape(v) + 64'd3 * smooth_shape(v)) / 64'd10;
            default:      shaped = '0;
        endcase
        amt    = (c.ride_amount > AMT_FULL) ? 64'(AMT_FULL) : 64'(c.ride_amount);
        ride   = (shaped * amt) >> 16;
        res_lo = 64'(c.resonance_floor);
        res_hi = 64'(c.resonance_ceiling);
        span   = res_hi - res_lo;
        // The scaled ride is truncated toward zero for an inverted range.
        if (span >= 0)
            add = (ride * span) >>> FRAC_BITS;
        else
            add = -((ride * (-span)) >>> FRAC_BITS);
        res = 64'(base_in);
        res = res + add;
        if (res > res_hi)
            res = res_hi;
        if (res < res_lo)
            res = res_lo;
        return res[15:0];
    endfunction

    function automatic logic [31:0] span_recip(input logic [15:0] lo, input logic [15:0] hi);
        logic [63:0] q;
        if (hi <= lo)
            return '1;
        q = (64'd1 << 32) / 64'(hi - lo);
        return (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
    endfunction

    function automatic void add_row(input cfg_t c, input logic [15:0] cut,
                                    input logic [15:0] res, input bit known,
                                    input logic [15:0] value);
        stim_row_t row;
        row.cfg         = c;
        row.cutoff      = cut;
        row.resonance   = res;
        row.known       = known;
        row.known_value = value;
        stim_table.push_back(row);
    endfunction

    function automatic void build_stim_table();
        cfg_t c;
        c = CFG_RESET;
        // Pass-through while disabled.
        add_row(c, 16'd0, 16'd0, 1'b1, 16'd0);
        add_row(c, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        add_row(c, 16'd20000, 16'd12345, 1'b1, 16'd12345);
        c.ride_enabled = 1'b1;
        add_row(c, 16'd0, 16'd0, 1'b0, 16'd0);
        add_row(c, 16'd10000, 16'd2000, 1'b0, 16'd0);
        add_row(c, 16'hFFFF, 16'hFFFF, 1'b1, 16'd62259);
        c.span_reciprocal = span_recip(c.cutoff_floor, c.cutoff_ceiling);
        add_row(c, 16'd20, 16'd0, 1'b0, 16'd0);
        add_row(c, 16'd5000, 16'd1000, 1'b0, 16'd0);
        c.curve_select = CURVE_LOG;
        add_row(c, 16'd20, 16'd0, 1'b0, 16'd0);
        add_row(c, 16'd7777, 16'd300, 1'b0, 16'd0);
        c.curve_select = CURVE_SMOOTH;
        add_row(c, 16'd10010, 16'd0, 1'b0, 16'd0);
        c.curve_select = CURVE_LINEAR;
        add_row(c, 16'd15000, 16'd500, 1'b0, 16'd0);
        c.curve_select = CURVE_BLEND;
        add_row(c, 16'd3000, 16'd0, 1'b0, 16'd0);
        add_row(c, 16'd20000, 16'd40000, 1'b0, 16'd0);
        // Undefined curve codes contribute nothing, leaving only the clamp.
        c.curve_select = CURVE_UNUSED_LO;
        add_row(c, 16'd1000, 16'd40000, 1'b1, 16'd40000);
        c.curve_select = CURVE_UNUSED_HI;
        add_row(c, 16'd1000, 16'hFFFF, 1'b1, 16'd62259);
        c.curve_select = CURVE_EXP;
        c.ride_amount  = 17'h1FFFF;
        add_row(c, 16'd100, 16'd1000, 1'b0, 16'd0);
        c.ride_amount = '0;
        add_row(c, 16'd100, 16'd30000, 1'b1, 16'd30000);
        // Full linear ride over the whole resonance range.
        c.curve_select      = CURVE_LINEAR;
        c.ride_amount       = AMT_FULL;
        c.resonance_floor   = 16'd0;
        c.resonance_ceiling = 16'hFFFF;
        c.cutoff_floor      = 16'd1000;
        c.cutoff_ceiling    = 16'd1000;
        add_row(c, 16'd30000, 16'd5, 1'b1, 16'hFFFF);
        c.cutoff_floor   = 16'd30000;
        c.cutoff_ceiling = 16'd100;
        add_row(c, 16'd5000, 16'd0, 1'b1, 16'hFFFF);
        // An oversized reciprocal pins the position at one.
        c.cutoff_floor    = 16'd0;
        c.cutoff_ceiling  = 16'hFFFF;
        c.span_reciprocal = 32'hFFFF_FFFF;
        add_row(c, 16'hFFFF, 16'd777, 1'b1, 16'd777);
        // With the resonance range inverted the floor always wins.
        c.span_reciprocal   = span_recip(16'd0, 16'hFFFF);
        c.resonance_floor   = 16'd50000;
        c.resonance_ceiling = 16'd10000;
        add_row(c, 16'd0, 16'd0, 1'b1, 16'd50000);
        add_row(c, 16'hFFFF, 16'hFFFF, 1'b1, 16'd50000);
    endfunction

    function automatic cfg_t random_cfg(input int kind);
        cfg_t c;
        c = CFG_RESET;
        if (kind == 0)
        begin
            c.ride_enabled      = 1'b1;
            c.curve_select      = CURVE_W'($urandom_range(CURVE_EXP, CURVE_BLEND));
            c.cutoff_floor      = 16'd0;
            c.cutoff_ceiling    = 16'hFFFF;
            c.span_reciprocal   = span_recip(16'd0, 16'hFFFF);
            c.resonance_floor   = 16'd0;
            c.resonance_ceiling = 16'hFFFF;
            c.ride_amount       = AMT_FULL;
        end
        else if (kind == SETTINGS_PER_PASS - 1)
        begin
            c.ride_enabled      = 1'($urandom_range(0, 1));
            c.curve_select      = CURVE_W'($urandom_range(0, 7));
            c.cutoff_floor      = 16'($urandom);
            c.cutoff_ceiling    = 16'($urandom);
            c.span_reciprocal   = $urandom;
            c.resonance_floor   = 16'($urandom);
            c.resonance_ceiling = 16'($urandom);
            c.ride_amount       = AMT_W'($urandom_range(0, 131071));
        end
        else
        begin
            c.ride_enabled      = ($urandom_range(0, 7) != 0);
            c.curve_select      = CURVE_W'($urandom_range(CURVE_EXP, CURVE_BLEND));
            c.cutoff_floor      = 16'($urandom_range(0, 40000));
            c.cutoff_ceiling    = 16'($urandom_range(c.cutoff_floor + 1, 65535));
            c.span_reciprocal   = span_recip(c.cutoff_floor, c.cutoff_ceiling);
            c.resonance_floor   = 16'($urandom_range(0, 30000));
            c.resonance_ceiling = 16'($urandom_range(c.resonance_floor + 1, 65535));
            c.ride_amount       = AMT_W'($urandom_range(0, 65536));
        end
        return c;
    endfunction

    task automatic put_reg(input reg_index_t idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        put_reg(REG_RIDE_ENABLED, 32'(c.ride_enabled));
        put_reg(REG_CURVE_SELECT, 32'(c.curve_select));
        put_reg(REG_CUTOFF_FLOOR, 32'(c.cutoff_floor));
        put_reg(REG_CUTOFF_CEILING, 32'(c.cutoff_ceiling));
        put_reg(REG_SPAN_RECIPROCAL, c.span_reciprocal);
        put_reg(REG_RESONANCE_FLOOR, 32'(c.resonance_floor));
        put_reg(REG_RESONANCE_CEILING, 32'(c.resonance_ceiling));
        put_reg(REG_RIDE_AMOUNT, 32'(c.ride_amount));
        cfg_we     <= 1'b0;
        active_cfg = c;
    endtask

    // Stop offering words and let the pipeline empty.
    task automatic settle();
        item_valid <= 1'b0;
        while (resonance_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Valid is lowered only for a gap, so back-to-back words keep it high.
    task automatic send_word(input logic [15:0] cut, input logic [15:0] res,
                             input bit known, input logic [15:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid     <= 1'b1;
        base_cutoff    <= cut;
        base_resonance <= res;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        resonance_due.push_back(known ? value : predict_resonance(active_cfg, cut, res));
    endtask

    initial
    begin
        logic [15:0] want;
        int          stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (resonance_due.size() == 0)
                begin
                    $error("effective_resonance: unexpected word, actual %0d",
                           effective_resonance);
                    failures++;
                end
                else
                begin
                    want = resonance_due.pop_front();
                    if (effective_resonance !== want)
                    begin
                        $error("effective_resonance: expected %0d, actual %0d",
                               want, effective_resonance);
                        failures++;
                    end
                end
            end
            if (stall_due)
            begin
                stall_left = LONG_STALL;
                stall_due  = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [15:0] cut;
        logic [15:0] res;
        int          pick;
        fill_curve_tables();
        build_stim_table();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].cfg != active_cfg)
            begin
                settle();
                apply_config(stim_table[i].cfg);
            end
            send_word(stim_table[i].cutoff, stim_table[i].resonance,
                      stim_table[i].known, stim_table[i].known_value);
        end

        for (int pass = 0; pass < 3; pass++)
        begin
            send_idle_pct = (pass == 0) ? 33 : (pass == 1) ? 67 : 0;
            recv_idle_pct = (pass == 0) ? 67 : (pass == 1) ? 33 : 0;
            for (int s = 0; s < SETTINGS_PER_PASS; s++)
            begin
                settle();
                apply_config(random_cfg(s));
                // Hold the result side off so the pipeline backs up into the input.
                if (pass == 2 && s == 0)
                    stall_due = 1'b1;
                for (int n = 0; n < WORDS_PER_SETTING; n++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        cut = 16'($urandom_range(active_cfg.cutoff_floor,
                                                 active_cfg.cutoff_ceiling));
                    else if (pick < 9)
                        cut = 16'($urandom);
                    else
                        cut = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    if ($urandom_range(0, 15) == 0)
                        res = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    else
                        res = 16'($urandom);
                    send_word(cut, res, 1'b0, 16'd0);
                end
            end
        end

        settle();
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
